@@ hdl/kvt_pkg.sv @@
package kvt_pkg;

    localparam int ENTRIES_DEF = 128;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;

    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [STAT_W-1:0] t_status;

    localparam t_req REQ_PUT = 2'd0;
    localparam t_req REQ_GET = 2'd1;
    localparam t_req REQ_DEL = 2'd2;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_MISS = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_slot;

    typedef struct packed {
        logic hit;
        logic free;
    } t_flags;

endpackage

@@ hdl/kvt_ram.sv @@
module kvt_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

@@ hdl/kvt_match.sv @@
module kvt_match #(
    parameter int AW = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_vld,
    input  logic [AW-1:0]            i_addr,
    input  kvt_pkg::t_slot           i_slot,
    input  logic [kvt_pkg::KEY_W-1:0] i_key,
    output kvt_pkg::t_flags          o_flags,
    output logic [AW-1:0]            o_hit_at,
    output logic [AW-1:0]            o_free_at
);
    import kvt_pkg::*;

    t_flags        r_flags;
    logic [AW-1:0] r_hit_at;
    logic [AW-1:0] r_free_at;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
        end else if (i_vld) begin
            if (i_slot.valid && !r_flags.hit && i_slot.key == i_key) begin
                r_flags.hit <= 1'b1;
            end
            if (!i_slot.valid && !r_flags.free) begin
                r_flags.free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld && i_slot.valid && !r_flags.hit && i_slot.key == i_key) begin
            r_hit_at <= i_addr;
        end
        if (i_vld && !i_slot.valid && !r_flags.free) begin
            r_free_at <= i_addr;
        end
    end

    assign o_flags   = r_flags;
    assign o_hit_at  = r_hit_at;
    assign o_free_at = r_free_at;

endmodule

@@ hdl/key_value_table_unit.sv @@
// Key/value table with linear search. A request is taken when start is high
// and busy is low; every request gives exactly one result beat on o_strobe,
// once the search states S_SCAN, S_TAIL and S_ACT (and S_GET for a get) are
// through; the search reads the key memory one entry per cycle. The receiver
// cannot stall: o_status and o_read_value are valid only in the single cycle
// o_strobe is high. After reset the block sweeps the key memory to mark every
// slot empty, holding busy high until the sweep has written the last slot.
module key_value_table_unit #(
    parameter int ENTRIES = kvt_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [kvt_pkg::REQ_W-1:0]   i_req_type,
    input  logic [kvt_pkg::KEY_W-1:0]   i_key,
    input  logic [kvt_pkg::VAL_W-1:0]   i_value,
    output logic                        o_strobe,
    output logic [kvt_pkg::STAT_W-1:0]  o_status,
    output logic [kvt_pkg::VAL_W-1:0]   o_read_value
);
    import kvt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_ACT,
        S_GET
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_cmp_addr;
    logic             r_cmp_vld;
    t_req             r_req;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic             r_strobe;
    t_status          r_status;
    logic [VAL_W-1:0] r_read_value;

    logic             accept;
    t_flags           flags;
    logic [AW-1:0]    hit_at;
    logic [AW-1:0]    free_at;

    logic             key_we;
    logic [AW-1:0]    key_addr;
    t_slot            key_wdata;
    t_slot            key_rdata;
    logic             val_we;
    logic [AW-1:0]    val_addr;
    logic [VAL_W-1:0] val_rdata;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        key_we    = 1'b0;
        key_addr  = r_addr;
        key_wdata = '0;
        val_we    = 1'b0;
        val_addr  = flags.hit ? hit_at : free_at;
        unique case (r_state)
            S_CLEAR: begin
                key_we = 1'b1;
            end
            S_ACT: begin
                if (r_req == REQ_DEL) begin
                    key_addr = hit_at;
                    key_we   = flags.hit;
                end else begin
                    key_addr        = free_at;
                    key_wdata.valid = 1'b1;
                    key_wdata.key   = r_key;
                    key_we          = (r_req == REQ_PUT) && !flags.hit && flags.free;
                end
                val_we = (r_req == REQ_PUT) && (flags.hit || flags.free);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe  <= 1'b0;
            r_cmp_vld <= (r_state == S_SCAN);
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_addr == LAST) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_TAIL: begin
                    r_state <= S_ACT;
                end
                S_ACT: begin
                    r_read_value <= '0;
                    case (r_req)
                        REQ_PUT: begin
                            r_status <= (flags.hit || flags.free) ? ST_OK : ST_FULL;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        REQ_GET: begin
                            r_state <= S_GET;
                        end
                        REQ_DEL: begin
                            r_status <= flags.hit ? ST_OK : ST_MISS;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    endcase
                end
                S_GET: begin
                    r_status     <= flags.hit ? ST_OK : ST_MISS;
                    r_read_value <= flags.hit ? val_rdata : '0;
                    r_strobe     <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_addr;
        if (accept) begin
            r_req <= i_req_type;
            r_key <= i_key;
            r_val <= i_value;
        end
    end

    kvt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(t_slot))
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_addr  (key_addr),
        .i_wdata (key_wdata),
        .o_rdata (key_rdata)
    );

    kvt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (VAL_W)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_addr  (val_addr),
        .i_wdata (r_val),
        .o_rdata (val_rdata)
    );

    kvt_match #(
        .AW (AW)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (accept),
        .i_vld     (r_cmp_vld),
        .i_addr    (r_cmp_addr),
        .i_slot    (key_rdata),
        .i_key     (r_key),
        .o_flags   (flags),
        .o_hit_at  (hit_at),
        .o_free_at (free_at)
    );

    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_read_value = r_read_value;

`ifndef SYNTHESIS
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_OK || o_status == ST_MISS || o_status == ST_FULL))
        else $error("undefined status code");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_read_value == '0))
        else $error("read value not zero on failed request");
`endif

endmodule
